>>> design/swod_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swod_pkg
// Shared constants and types for the sliding-window outlier detector.
// ----------------------------------------------------------------------------
package swod_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int WINDOW_DEF  = 64;
	localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int TUSER_W     = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int OUT_DEPTH   = 2;

	localparam logic [SAMPLE_BITS-1:0] DRY_RESET = SAMPLE_BITS'(3700);

	// classified item handed from front to back
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   dry;
	} swod_item_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   significant;
		logic                   dry;
	} swod_result_t;

endpackage
`default_nettype wire

>>> design/swod_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swod_fifo
// Small register FIFO with valid/ready on both sides.
// ----------------------------------------------------------------------------
module swod_fifo import swod_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [WIDTH-1:0] in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [WIDTH-1:0]      out_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/swod_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swod_front
// Input side: holds the dry threshold, tags each sample and queues it.
// ----------------------------------------------------------------------------
module swod_front import swod_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [SAMPLE_BITS-1:0] cfg_wr_data,
	input  wire logic                   s_valid,
	output logic                        s_ready,
	input  wire logic [SAMPLE_BITS-1:0] s_sample,
	output logic                        q_valid,
	input  wire logic                   q_ready,
	output swod_item_t                  q_item
);

	logic [SAMPLE_BITS-1:0] thr_q;
	swod_item_t             item_in;
	logic [$bits(swod_item_t)-1:0] q_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= DRY_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	always_comb begin
		item_in.sample = s_sample;
		item_in.dry    = (s_sample > thr_q);
	end

	swod_fifo #(
		.WIDTH ($bits(swod_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_valid),
		.in_ready  (s_ready),
		.in_data   (item_in),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_bits)
	);

	assign q_item = swod_item_t'(q_bits);

endmodule
`default_nettype wire

>>> design/swod_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swod_back
// Window engine: ring memory, running sums, one-sigma test, result queue.
// ----------------------------------------------------------------------------
module swod_back import swod_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   q_valid,
	output logic        q_ready,
	input  swod_item_t  q_item,
	output logic        m_valid,
	input  wire logic   m_ready,
	output swod_result_t m_result
);

	localparam int PTR_W  = $clog2(WINDOW);
	localparam int SUM_W  = SAMPLE_BITS + PTR_W;
	localparam int SQR_W  = 2 * SAMPLE_BITS;
	localparam int SQ_W   = SQR_W + PTR_W;
	localparam int PROD_W = 2 * SUM_W;
	localparam int CNT_W  = $clog2(OUT_DEPTH + 1);

	// ring, cleared at reset through per-entry valid bits
	logic [SAMPLE_BITS-1:0] ring [WINDOW];
	logic [WINDOW-1:0]      ent_vld_q;
	logic [SAMPLE_BITS-1:0] rd_data_q;

	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  ptr_next;
	logic [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]   sq_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              pop;
	logic              out_hs;
	logic [SUM_W-1:0]  nx;
	logic [SUM_W-1:0]  dev;

	// stage 1: judged against the current sums, outgoing entry being read
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] x_s1;
	logic                   dry_s1;
	logic [SUM_W-1:0]       dev_s1;
	logic [PROD_W-1:0]      ssq_s1;
	logic [PROD_W-1:0]      nq_s1;
	logic [SQR_W-1:0]       xx_s1;
	logic [PTR_W-1:0]       ptr_s1;
	logic                   old_vld_s1;

	logic [SAMPLE_BITS-1:0] old;
	logic [SQR_W-1:0]       old_sq;

	// stage 2: squared deviation against variance term
	logic                   valid_s2;
	logic [SAMPLE_BITS-1:0] x_s2;
	logic                   dry_s2;
	logic [PROD_W-1:0]      lhs_s2;
	logic [PROD_W-1:0]      rhs_s2;

	swod_result_t           res;

	assign ptr_next = (wp_q == PTR_W'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
	assign q_ready  = !valid_s1 && (cnt_q < CNT_W'(OUT_DEPTH));
	assign pop      = q_valid && q_ready;
	assign out_hs   = m_valid && m_ready;

	always_comb begin
		nx  = SUM_W'(q_item.sample) * SUM_W'(WINDOW);
		dev = (nx >= sum_q) ? (nx - sum_q) : (sum_q - nx);
	end

	always_comb begin
		old    = old_vld_s1 ? rd_data_q : '0;
		old_sq = SQR_W'(old) * SQR_W'(old);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_data_q <= ring[ptr_next];
		end
		if (valid_s1) begin
			ring[ptr_s1] <= x_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_s1       <= q_item.sample;
			dry_s1     <= q_item.dry;
			dev_s1     <= dev;
			ssq_s1     <= PROD_W'(sum_q) * PROD_W'(sum_q);
			nq_s1      <= PROD_W'(sq_q) * PROD_W'(WINDOW);
			xx_s1      <= SQR_W'(q_item.sample) * SQR_W'(q_item.sample);
			ptr_s1     <= ptr_next;
			old_vld_s1 <= ent_vld_q[ptr_next];
		end
		if (valid_s1) begin
			x_s2   <= x_s1;
			dry_s2 <= dry_s1;
			lhs_s2 <= PROD_W'(dev_s1) * PROD_W'(dev_s1);
			rhs_s2 <= nq_s1 - ssq_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			ent_vld_q <= '0;
			wp_q      <= PTR_W'(WINDOW - 1);
			sum_q     <= '0;
			sq_q      <= '0;
			cnt_q     <= '0;
		end else begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				ent_vld_q[ptr_s1] <= 1'b1;
				wp_q  <= ptr_s1;
				sum_q <= sum_q - SUM_W'(old) + SUM_W'(x_s1);
				sq_q  <= sq_q - SQ_W'(old_sq) + SQ_W'(xx_s1);
			end
			// results in flight or queued; the output queue can never overflow
			if (pop && !out_hs) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (out_hs && !pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_comb begin
		res.sample      = x_s2;
		res.significant = (lhs_s2 >= rhs_s2);
		res.dry         = dry_s2;
	end

	logic [$bits(swod_result_t)-1:0] out_bits;

	swod_fifo #(
		.WIDTH ($bits(swod_result_t)),
		.DEPTH (OUT_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_ready  (),
		.in_data   (res),
		.out_valid (m_valid),
		.out_ready (m_ready),
		.out_data  (out_bits)
	);

	assign m_result = swod_result_t'(out_bits);

endmodule
`default_nettype wire

>>> design/sliding_window_outlier_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_outlier_detector
// Flags samples lying at least one standard deviation from the window mean.
// ----------------------------------------------------------------------------
// Samples arrive as beats on the s_axis channel (tdata[11:0]); one result beat
// per sample leaves on m_axis: tdata carries the sample, tuser its flags.
// The dry threshold is loaded through cfg_wr_en/cfg_wr_data; the user must load
// it only while idle, as the block itself does not enforce this.
// A sample passes the input queue, stage 1, stage 2 and the result queue.
// The running-sum loop paces the engine: the outgoing ring entry is read as a
// sample is taken, the sums are updated in the next cycle, and the following
// sample is taken only after that, as it must be judged against the new sums.
// A two-entry queue sits between intake and the window engine, and a two-entry
// result queue at the output, so s_axis keeps taking beats while a result
// waits. If m_axis stalls, the engine halts once two results are outstanding
// and the input queue fills, after which s_axis_tready drops.
// Reset clears the ring (per-entry valid bits), the sums and the queues and
// restores the threshold to 3700; no clearing pass is needed, so the block
// accepts samples as soon as reset is released.
// ----------------------------------------------------------------------------
module sliding_window_outlier_detector import swod_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [SAMPLE_BITS-1:0] cfg_wr_data,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [TDATA_W-1:0]     s_axis_tdata,  // [11:0] sample
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [TDATA_W-1:0]          m_axis_tdata,  // [11:0] sample_echo
	output logic [TUSER_W-1:0]          m_axis_tuser   // [0] significant, [1] dry
);

	logic         q_valid;
	logic         q_ready;
	swod_item_t   q_item;
	swod_result_t result;

	swod_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_valid     (s_axis_tvalid),
		.s_ready     (s_axis_tready),
		.s_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_item      (q_item)
	);

	swod_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item),
		.m_valid  (m_axis_tvalid),
		.m_ready  (m_axis_tready),
		.m_result (result)
	);

	assign m_axis_tdata = {{(TDATA_W - SAMPLE_BITS){1'b0}}, result.sample};
	assign m_axis_tuser = {result.dry, result.significant};

endmodule
`default_nettype wire

>>> design/swod_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swod_checker
// Port-level checks for the outlier detector, bound to the top level.
// ----------------------------------------------------------------------------
module swod_checker import swod_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   cfg_wr_en,
	input wire logic [SAMPLE_BITS-1:0] cfg_wr_data,
	input wire logic                   s_axis_tvalid,
	input wire logic                   s_axis_tready,
	input wire logic [TDATA_W-1:0]     s_axis_tdata,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [TDATA_W-1:0]     m_axis_tdata,
	input wire logic [TUSER_W-1:0]     m_axis_tuser
);

	logic [SAMPLE_BITS-1:0] thr_q;
	logic [7:0]             pend_q;
	logic                   in_hs;
	logic                   out_hs;

	assign in_hs  = s_axis_tvalid && s_axis_tready;
	assign out_hs = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= DRY_RESET;
			pend_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (in_hs && !out_hs) begin
				pend_q <= pend_q + 1'b1;
			end else if (out_hs && !in_hs) begin
				pend_q <= pend_q - 1'b1;
			end
		end
	end

	// a result beat always belongs to an earlier sample beat
	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs |-> (pend_q != '0))
		else $error("result beat without pending sample");

	// dry flag agrees with the echoed sample and the loaded threshold
	a_dry_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[1] == (m_axis_tdata[SAMPLE_BITS-1:0] > thr_q)))
		else $error("dry flag mismatch");

	// padding bits above the sample stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[TDATA_W-1:SAMPLE_BITS] == '0))
		else $error("tdata padding not zero");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result beat changed");

endmodule

bind sliding_window_outlier_detector swod_checker u_swod_checker (.*);
`default_nettype wire
